FILE: src/plist_pkg.sv
// Shared types, codes and sizing constants for the positional list engine.
`timescale 1ns / 1ps

package plist_pkg;

  localparam int CAPACITY  = 16;
  localparam int ITEM_BITS = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_RM_FRONT  = 3'd3,
    REQ_RM_BACK   = 3'd4,
    REQ_RM_POS    = 3'd5,
    REQ_RM_VALUE  = 3'd6
  } req_code_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_code_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE_POS,
    CM_REMOVE_VAL
  } cell_mode_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [4:0]         position;
  } plist_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] count;
  } plist_out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_mode_t           mode;
    logic [CNT_W-1:0]     target;
    logic [CNT_W-1:0]     count;
    logic [ITEM_BITS-1:0] key;
  } cell_cmd_t;

endpackage

FILE: src/plist_cell.sv
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps

module plist_cell import plist_pkg::*; (
  input  logic                 clk,
  input  logic [CNT_W-1:0]     idx,
  input  cell_cmd_t            cmd,
  input  logic [ITEM_BITS-1:0] left_data,
  input  logic [ITEM_BITS-1:0] right_data,
  input  logic                 found_in,
  output logic                 found_out,
  output logic                 match_out,
  output logic [ITEM_BITS-1:0] data
);

  logic [ITEM_BITS-1:0] data_r;
  logic [ITEM_BITS-1:0] data_nxt;
  logic                 in_range;
  logic                 match;

  assign in_range  = idx < cmd.count;
  assign match     = in_range && (data_r == cmd.key);
  assign found_out = found_in | match;
  assign match_out = match;
  assign data      = data_r;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.mode)
      CM_INSERT: begin
        if (idx > cmd.target) begin
          data_nxt = left_data;
        end else if (idx == cmd.target) begin
          data_nxt = cmd.key;
        end
      end
      CM_REMOVE_POS: begin
        if (idx >= cmd.target) begin
          data_nxt = right_data;
        end
      end
      CM_REMOVE_VAL: begin
        if (found_in | match) begin
          data_nxt = right_data;
        end
      end
      CM_HOLD: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: src/positional_list_engine.sv
// Top level of the positional list engine: request decode, entry count and the cell chain.
`timescale 1ns / 1ps

// The engine keeps an ordered list of up to CAPACITY signed items in a row of
// cells. A request is transferred at a rising edge where start is high and busy
// is low; in_data carries the request code, the value and the position.
// Busy is high after a transfer, while the chain executes.
// While busy, every cell compares its entry against the key; unless the request
// fails, entries from the affected place on shift left or right by one at once.
// The result (status and the new entry count) appears on out_data with
// out_valid high for exactly one cycle, the cycle after the execute cycle,
// which is also the first cycle in which a new request can be transferred.
// The receiver cannot stall the engine; it must take the result in that cycle.
// A value removal checks the front entry first, then the back entry, then the
// middle entries from the front, and removes the first entry that matches in
// that order.
// Synchronous reset empties the list (the count goes to zero) and drops any
// pending result; the cell contents are left as they are and are never read
// before they are written again.

module positional_list_engine import plist_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  plist_in_t  in_data,
  output logic       out_valid,
  output plist_out_t out_data
);

  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t           state_r;
  plist_in_t        req_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  plist_out_t       out_data_r;
  status_code_t     status_nxt;
  cell_cmd_t        cmd;

  logic [ITEM_BITS-1:0] cell_data [CAPACITY];
  logic                 found     [CAPACITY+1];
  logic                 cell_hit  [CAPACITY];

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CNT_W-1:0] last_pos;
  logic             full;
  logic             empty;
  logic             front_hit;
  logic             back_hit;

  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos_w    = CMP_W'(req_r.position);
  assign cnt_w    = CMP_W'(count_r);
  assign last_pos = count_r - 1'b1;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  // The front cell and the cell holding the last entry, checked for a match.
  assign front_hit = cell_hit[0];

  always_comb begin
    back_hit = 1'b0;
    for (int j = 0; j < CAPACITY; j++) begin
      if ((CNT_W'(j) == last_pos) && cell_hit[j]) begin
        back_hit = 1'b1;
      end
    end
  end

  // Request decode: the command for the chain, the status and the new count.
  always_comb begin
    cmd.mode   = CM_HOLD;
    cmd.target = '0;
    cmd.count  = count_r;
    cmd.key    = ITEM_BITS'(req_r.value);
    status_nxt = ST_OK;
    count_nxt  = count_r;
    if (state_r == S_EXEC) begin
      unique case (req_r.req_type)
        REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
          if ((req_r.req_type == REQ_INS_POS) && (pos_w > cnt_w)) begin
            status_nxt = ST_RANGE;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.mode  = CM_INSERT;
            count_nxt = count_r + 1'b1;
            if (req_r.req_type == REQ_INS_FRONT) begin
              cmd.target = '0;
            end else if (req_r.req_type == REQ_INS_BACK) begin
              cmd.target = count_r;
            end else begin
              cmd.target = CNT_W'(req_r.position);
            end
          end
        end
        REQ_RM_FRONT, REQ_RM_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.mode   = CM_REMOVE_POS;
            cmd.target = (req_r.req_type == REQ_RM_FRONT) ? '0 : count_r - 1'b1;
            count_nxt  = count_r - 1'b1;
          end
        end
        REQ_RM_POS: begin
          if (pos_w >= cnt_w) begin
            status_nxt = ST_RANGE;
          end else begin
            cmd.mode   = CM_REMOVE_POS;
            cmd.target = CNT_W'(req_r.position);
            count_nxt  = count_r - 1'b1;
          end
        end
        REQ_RM_VALUE: begin
          // The front entry wins, then the back entry. Otherwise the cells at
          // and after the first middle match shift left; with no match
          // nothing moves.
          if (front_hit) begin
            cmd.mode   = CM_REMOVE_POS;
            cmd.target = '0;
            count_nxt  = count_r - 1'b1;
          end else if (back_hit) begin
            cmd.mode   = CM_REMOVE_POS;
            cmd.target = last_pos;
            count_nxt  = count_r - 1'b1;
          end else if (found[CAPACITY]) begin
            cmd.mode  = CM_REMOVE_VAL;
            count_nxt = count_r - 1'b1;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        default: begin
          // The unused request code leaves the list alone and reports ok.
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // The cell chain. Cell 0 sits at the front of the list.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_BITS-1:0] left_d;
    logic [ITEM_BITS-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    plist_cell u_cell (
      .clk        (clk),
      .idx        (CNT_W'(i)),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .match_out  (cell_hit[i]),
      .data       (cell_data[i])
    );
  end

  // Sequencer, request register, entry count and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r   <= in_data;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          count_r           <= count_nxt;
          out_data_r.status <= status_nxt;
          out_data_r.count  <= 5'(count_nxt);
          out_valid_r       <= 1'b1;
          state_r           <= S_IDLE;
        end
      endcase
    end
  end

endmodule
